[rtl/core/fmbp_pkg.sv]
// ----------------------------------------------------------------------------
// fmbp_pkg - shared definitions for the framed message byte parser
// Parse phase codes, error codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package fmbp_pkg;

  // Default frame size limit in bytes (header, data and trailer)
  localparam int unsigned DEF_MAX_FRAME_BYTES = 256;

  // Bytes of framing around the data: start, dest, src, count, len x2, csum, end
  localparam int unsigned FRAME_OVERHEAD = 8;

  // Parse phase codes
  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_IDLE   = 4'd0;
  localparam logic [PH_W-1:0] PH_DEST   = 4'd1;
  localparam logic [PH_W-1:0] PH_SRC    = 4'd2;
  localparam logic [PH_W-1:0] PH_COUNT  = 4'd3;
  localparam logic [PH_W-1:0] PH_LEN_HI = 4'd4;
  localparam logic [PH_W-1:0] PH_LEN_LO = 4'd5;
  localparam logic [PH_W-1:0] PH_DATA   = 4'd6;
  localparam logic [PH_W-1:0] PH_CSUM   = 4'd7;
  localparam logic [PH_W-1:0] PH_END    = 4'd8;

  // Error codes reported on the byte that reveals the fault
  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE        = 3'd0;
  localparam err_t ERR_BAD_DEST    = 3'd1;
  localparam err_t ERR_BAD_SOURCE  = 3'd2;
  localparam err_t ERR_LENGTH      = 3'd3;
  localparam err_t ERR_EARLY_START = 3'd4;
  localparam err_t ERR_EARLY_END   = 3'd5;
  localparam err_t ERR_CHECKSUM    = 3'd6;
  localparam err_t ERR_NO_END      = 3'd7;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_START_BYTE = 3'd0;
  localparam cfg_idx_t REG_END_BYTE   = 3'd1;
  localparam cfg_idx_t REG_OWN_ID     = 3'd2;
  localparam cfg_idx_t REG_PEER_A     = 3'd3;
  localparam cfg_idx_t REG_PEER_B     = 3'd4;
  localparam cfg_idx_t REG_PEER_C     = 3'd5;
  localparam cfg_idx_t REG_PEER_D     = 3'd6;

  // Configuration reset values
  localparam logic [7:0] RST_START_BYTE = 8'd2;
  localparam logic [7:0] RST_END_BYTE   = 8'd3;
  localparam logic [7:0] RST_OWN_ID     = 8'd109;
  localparam logic [7:0] RST_PEER_A     = 8'd115;
  localparam logic [7:0] RST_PEER_B     = 8'd112;
  localparam logic [7:0] RST_PEER_C     = 8'd116;
  localparam logic [7:0] RST_PEER_D     = 8'd103;

  // Checksum seed
  localparam logic [7:0] SUM_SEED = 8'hFF;

endpackage

[rtl/core/framed_message_byte_parser.sv]
// ----------------------------------------------------------------------------
// framed_message_byte_parser - start/end framed packet parser
// Parses dest, source, count, 16-bit length, data, additive checksum and end
// byte from a byte stream; one result beat per input beat.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready  | in_byte
// out_    | output    | out_valid/out_ready| data_valid, data_byte, data_index,
//         |           |                    | source_id, message_count,
//         |           |                    | error_code, frame_valid
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input beat per clock; its result appears in the output register on the
// next cycle. The parse state and the result register update in the same
// edge, so throughput is one byte per cycle while out_ready stays high.
// A stalled output holds in_ready low only while the result is not taken.
// Synchronous active-low reset clears the parse state, the output valid and
// loads the register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module framed_message_byte_parser
  import fmbp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  // input byte channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_data_index,
  output logic [7:0] out_source_id,
  output logic [7:0] out_message_count,
  output logic [2:0] out_error_code,
  output logic       out_frame_valid,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Limits, compared at 17 bits so that a 65536-byte limit fits
  localparam logic [16:0] MAX_LEN  = 17'(MAX_FRAME_BYTES - FRAME_OVERHEAD);
  localparam logic [16:0] MAX_IDX  = 17'(MAX_FRAME_BYTES);

  // Configuration registers
  logic [7:0] start_byte_r, end_byte_r, own_id_r;
  logic [7:0] peer_a_r, peer_b_r, peer_c_r, peer_d_r;

  // Parse state
  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [15:0]     idx_r, idx_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      src_r, src_nxt;
  logic [7:0]      cnt_r, cnt_nxt;

  // Result of the current beat
  logic       dvalid_nxt, fvalid_nxt;
  logic [7:0] dbyte_nxt, dindex_nxt;
  err_t       err_nxt;

  // Output register
  logic       out_valid_r;
  logic       dvalid_r, fvalid_r;
  logic [7:0] dbyte_r, dindex_r, src_out_r, cnt_out_r;
  err_t       err_r;

  logic        in_acc;
  logic        is_peer;
  logic [15:0] len_full;
  logic [15:0] idx_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= RST_START_BYTE;
      end_byte_r   <= RST_END_BYTE;
      own_id_r     <= RST_OWN_ID;
      peer_a_r     <= RST_PEER_A;
      peer_b_r     <= RST_PEER_B;
      peer_c_r     <= RST_PEER_C;
      peer_d_r     <= RST_PEER_D;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte_r <= cfg_data;
        REG_END_BYTE:   end_byte_r   <= cfg_data;
        REG_OWN_ID:     own_id_r     <= cfg_data;
        REG_PEER_A:     peer_a_r     <= cfg_data;
        REG_PEER_B:     peer_b_r     <= cfg_data;
        REG_PEER_C:     peer_c_r     <= cfg_data;
        REG_PEER_D:     peer_d_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign is_peer  = (in_byte == peer_a_r) || (in_byte == peer_b_r) ||
                    (in_byte == peer_c_r) || (in_byte == peer_d_r);
  assign len_full = {len_r[15:8], in_byte};
  assign idx_inc  = idx_r + 16'd1;

  // Advance the parser by one byte
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    src_nxt    = src_r;
    cnt_nxt    = cnt_r;
    dvalid_nxt = 1'b0;
    dbyte_nxt  = 8'd0;
    dindex_nxt = 8'd0;
    err_nxt    = ERR_NONE;
    fvalid_nxt = 1'b0;
    unique case (phase_r)
      PH_DEST: begin
        if (in_byte == own_id_r) begin
          phase_nxt = PH_SRC;
        end else begin
          // a peer's frame is dropped quietly
          if (!is_peer) err_nxt = ERR_BAD_DEST;
          phase_nxt = PH_IDLE;
        end
      end
      PH_SRC: begin
        if (is_peer) begin
          src_nxt   = in_byte;
          phase_nxt = PH_COUNT;
        end else begin
          err_nxt   = ERR_BAD_SOURCE;
          phase_nxt = PH_IDLE;
        end
      end
      PH_COUNT: begin
        cnt_nxt   = in_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {in_byte, 8'd0};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt = len_full;
        if ({1'b0, len_full} > MAX_LEN) begin
          err_nxt   = ERR_LENGTH;
          phase_nxt = PH_IDLE;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CSUM;
        end else begin
          idx_nxt   = 16'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (in_byte == end_byte_r) begin
          err_nxt   = ERR_EARLY_END;
          phase_nxt = PH_IDLE;
        end else if (in_byte == start_byte_r) begin
          // resync on a new start byte
          err_nxt   = ERR_EARLY_START;
          idx_nxt   = 16'd0;
          len_nxt   = 16'd0;
          sum_nxt   = SUM_SEED;
          phase_nxt = PH_DEST;
        end else begin
          dvalid_nxt = 1'b1;
          dbyte_nxt  = in_byte;
          dindex_nxt = idx_r[7:0];
          sum_nxt    = sum_r + in_byte;
          idx_nxt    = idx_inc;
          if (idx_inc >= len_r || {1'b0, idx_inc} >= MAX_IDX) begin
            idx_nxt   = 16'd0;
            phase_nxt = PH_CSUM;
          end
        end
      end
      PH_CSUM: begin
        if (in_byte != sum_r) begin
          err_nxt   = ERR_CHECKSUM;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        phase_nxt = PH_IDLE;
        if (in_byte == end_byte_r) fvalid_nxt = 1'b1;
        else                       err_nxt    = ERR_NO_END;
      end
      default: begin
        // idle: clear counters, wait for a start byte
        idx_nxt   = 16'd0;
        len_nxt   = 16'd0;
        sum_nxt   = SUM_SEED;
        phase_nxt = (in_byte == start_byte_r) ? PH_DEST : PH_IDLE;
      end
    endcase
  end

  // Update parse state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= 16'd0;
      len_r   <= 16'd0;
      sum_r   <= SUM_SEED;
      src_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      src_r   <= src_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the result until the output beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dvalid_r  <= dvalid_nxt;
      dbyte_r   <= dbyte_nxt;
      dindex_r  <= dindex_nxt;
      src_out_r <= src_nxt;
      cnt_out_r <= cnt_nxt;
      err_r     <= err_nxt;
      fvalid_r  <= fvalid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_valid    = dvalid_r;
  assign out_data_byte     = dbyte_r;
  assign out_data_index    = dindex_r;
  assign out_source_id     = src_out_r;
  assign out_message_count = cnt_out_r;
  assign out_error_code    = err_r;
  assign out_frame_valid   = fvalid_r;

endmodule

[rtl/core/fmbp_checker.sv]
// ----------------------------------------------------------------------------
// fmbp_checker - port-level checks for the framed message byte parser
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module fmbp_checker
  import fmbp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_data_valid,
  input logic [7:0] out_data_byte,
  input logic [2:0] out_error_code,
  input logic       out_frame_valid
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

  // A stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte))
    else $error("stalled output beat dropped or changed");

  // A stored data byte never carries an error or a frame end
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_error_code == ERR_NONE && !out_frame_valid)
    else $error("data beat with error or frame end");

  // A good frame end carries no error
  a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_valid |-> out_error_code == ERR_NONE)
    else $error("frame end with error");

  // Each accepted input beat yields an output beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat gave no result");

endmodule

bind framed_message_byte_parser fmbp_checker u_fmbp_checker (.*);

[tb/sv/framed_message_byte_parser_tb.sv]
// ----------------------------------------------------------------------------
// framed_message_byte_parser_tb - self-checking bench for the frame parser
// Sends a directed table of frames and then random frames, some well formed
// and some broken, under several register settings. Each result beat is
// predicted from the bytes sent and compared field by field. The sender
// leaves random gaps and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module framed_message_byte_parser_tb;
  import fmbp_pkg::*;

  localparam int unsigned FRAME_LIMIT  = DEF_MAX_FRAME_BYTES;
  localparam int unsigned LEN_MAX      = FRAME_LIMIT - FRAME_OVERHEAD;
  localparam int unsigned NUM_REGS     = 7;
  localparam int unsigned RANDOM_BYTES = 120;     // per register setting
  localparam int unsigned TX_MAX_GAP   = 6;
  localparam int unsigned RX_MAX_STALL = 12;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned NUM_DIRECTED = 54;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] source_id;
    logic [7:0] message_count;
    err_t       error_code;
    logic       frame_valid;
  } parse_result_t;

  // One directed byte; pinned rows carry the error code and frame pulse
  typedef struct packed {
    logic [7:0] value;
    logic       pinned;
    err_t       err;
    logic       fv;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_data_valid;
  logic [7:0] out_data_byte;
  logic [7:0] out_data_index;
  logic [7:0] out_source_id;
  logic [7:0] out_message_count;
  logic [2:0] out_error_code;
  logic       out_frame_valid;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  framed_message_byte_parser #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_valid   (out_data_valid),
    .out_data_byte    (out_data_byte),
    .out_data_index   (out_data_index),
    .out_source_id    (out_source_id),
    .out_message_count(out_message_count),
    .out_error_code   (out_error_code),
    .out_frame_valid  (out_frame_valid),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Parser state as the bench sees it
  logic [7:0]      live_regs [NUM_REGS];
  logic [7:0]      reg_plan  [NUM_REGS];
  logic [PH_W-1:0] frm_phase;
  logic [15:0]     frm_index;
  logic [15:0]     frm_length;
  logic [7:0]      frm_sum;
  logic [7:0]      frm_source;
  logic [7:0]      frm_count;
  parse_result_t   expected_results [$];
  logic [7:0]      tx_frame [$];

  int unsigned cycle_count;
  int unsigned failures;
  int unsigned bytes_sent;
  int unsigned frames_good;
  int unsigned settings_used;
  int unsigned err_seen [8];
  int unsigned tx_burst_left;
  bit          tx_free_run;
  int unsigned rx_tick;
  int unsigned rx_stall;

  // Directed frames under the reset register values
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // idle bytes at both extremes
    '{8'h00, 1'b1, ERR_NONE, 1'b0},
    '{8'hFF, 1'b1, ERR_NONE, 1'b0},
    // unknown destination
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b1, ERR_BAD_DEST, 1'b0},
    // destination is a peer: drop silently
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_B, 1'b1, ERR_NONE, 1'b0},
    // unknown source
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{8'hFF, 1'b1, ERR_BAD_SOURCE, 1'b0},
    // length over the limit
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_A, 1'b0, ERR_NONE, 1'b0},
    '{8'hFF, 1'b0, ERR_NONE, 1'b0},
    '{8'hFF, 1'b0, ERR_NONE, 1'b0},
    '{8'hFF, 1'b1, ERR_LENGTH, 1'b0},
    // zero length, good frame
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_D, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{SUM_SEED, 1'b1, ERR_NONE, 1'b0},
    '{RST_END_BYTE, 1'b1, ERR_NONE, 1'b1},
    // start byte inside the data resyncs
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_C, 1'b0, ERR_NONE, 1'b0},
    '{8'h01, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h05, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'hFF, 1'b0, ERR_NONE, 1'b0},
    '{RST_START_BYTE, 1'b1, ERR_EARLY_START, 1'b0},
    // end byte inside the data, right after the resync
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_A, 1'b0, ERR_NONE, 1'b0},
    '{8'h07, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h01, 1'b0, ERR_NONE, 1'b0},
    '{RST_END_BYTE, 1'b1, ERR_EARLY_END, 1'b0},
    // wrong checksum
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_B, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b1, ERR_CHECKSUM, 1'b0},
    // missing end byte
    '{RST_START_BYTE, 1'b0, ERR_NONE, 1'b0},
    '{RST_OWN_ID, 1'b0, ERR_NONE, 1'b0},
    '{RST_PEER_B, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h00, 1'b0, ERR_NONE, 1'b0},
    '{8'h01, 1'b0, ERR_NONE, 1'b0},
    '{8'h80, 1'b0, ERR_NONE, 1'b0},
    '{8'h7F, 1'b0, ERR_NONE, 1'b0},
    '{8'h55, 1'b1, ERR_NO_END, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Frame prediction
  // --------------------------------------------------------------------------
  function automatic logic is_peer_id(logic [7:0] b);
    return b == live_regs[REG_PEER_A] || b == live_regs[REG_PEER_B] ||
           b == live_regs[REG_PEER_C] || b == live_regs[REG_PEER_D];
  endfunction

  function automatic void clear_frame_counters();
    frm_index  = '0;
    frm_length = '0;
    frm_sum    = SUM_SEED;
  endfunction

  function automatic void reset_parser_state();
    live_regs[REG_START_BYTE] = RST_START_BYTE;
    live_regs[REG_END_BYTE]   = RST_END_BYTE;
    live_regs[REG_OWN_ID]     = RST_OWN_ID;
    live_regs[REG_PEER_A]     = RST_PEER_A;
    live_regs[REG_PEER_B]     = RST_PEER_B;
    live_regs[REG_PEER_C]     = RST_PEER_C;
    live_regs[REG_PEER_D]     = RST_PEER_D;
    frm_phase  = PH_IDLE;
    clear_frame_counters();
    frm_source = '0;
    frm_count  = '0;
  endfunction

  // Advance the parse by one byte and return the result beat it causes
  function automatic parse_result_t parse_byte(logic [7:0] b);
    parse_result_t r;
    r = '0;
    case (frm_phase)
      PH_DEST: begin
        if (b == live_regs[REG_OWN_ID]) begin
          frm_phase = PH_SRC;
        end else begin
          if (!is_peer_id(b)) r.error_code = ERR_BAD_DEST;
          frm_phase = PH_IDLE;
        end
      end
      PH_SRC: begin
        if (is_peer_id(b)) begin
          frm_source = b;
          frm_phase  = PH_COUNT;
        end else begin
          r.error_code = ERR_BAD_SOURCE;
          frm_phase    = PH_IDLE;
        end
      end
      PH_COUNT: begin
        frm_count = b;
        frm_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frm_length = {b, 8'h00};
        frm_phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frm_length = frm_length | {8'h00, b};
        if (frm_length > LEN_MAX) begin
          r.error_code = ERR_LENGTH;
          frm_phase    = PH_IDLE;
        end else if (frm_length == 0) begin
          frm_phase = PH_CSUM;
        end else begin
          frm_index = '0;
          frm_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        // end byte wins when it equals the start byte
        if (b == live_regs[REG_END_BYTE]) begin
          r.error_code = ERR_EARLY_END;
          frm_phase    = PH_IDLE;
        end else if (b == live_regs[REG_START_BYTE]) begin
          r.error_code = ERR_EARLY_START;
          clear_frame_counters();
          frm_phase = PH_DEST;
        end else begin
          r.data_valid = 1'b1;
          r.data_byte  = b;
          r.data_index = frm_index[7:0];
          frm_sum      = frm_sum + b;
          frm_index    = frm_index + 16'd1;
          if (frm_index >= frm_length || frm_index >= FRAME_LIMIT) begin
            frm_index = '0;
            frm_phase = PH_CSUM;
          end
        end
      end
      PH_CSUM: begin
        if (b != frm_sum) begin
          r.error_code = ERR_CHECKSUM;
          frm_phase    = PH_IDLE;
        end else begin
          frm_phase = PH_END;
        end
      end
      PH_END: begin
        frm_phase = PH_IDLE;
        if (b == live_regs[REG_END_BYTE]) r.frame_valid = 1'b1;
        else r.error_code = ERR_NO_END;
      end
      default: begin
        clear_frame_counters();
        frm_phase = (b == live_regs[REG_START_BYTE]) ? PH_DEST : PH_IDLE;
      end
    endcase
    r.source_id     = frm_source;
    r.message_count = frm_count;
    return r;
  endfunction

  // Build one random frame into tx_frame: mostly well formed, some broken
  function automatic void build_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  sum;
    logic [7:0]  b;
    tx_frame.delete();
    // line noise ahead of the frame
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) tx_frame.push_back(8'($urandom));
    tx_frame.push_back(live_regs[REG_START_BYTE]);
    pick = $urandom_range(0, 19);
    if (pick < 17) tx_frame.push_back(live_regs[REG_OWN_ID]);
    else if (pick == 17) tx_frame.push_back(live_regs[int'(REG_PEER_A) + $urandom_range(0, 3)]);
    else tx_frame.push_back(8'($urandom));
    if ($urandom_range(0, 19) != 0)
      tx_frame.push_back(live_regs[int'(REG_PEER_A) + $urandom_range(0, 3)]);
    else
      tx_frame.push_back(8'($urandom));
    tx_frame.push_back(8'($urandom));
    // mostly short data, a few at the limit and a few over it
    pick = $urandom_range(0, 39);
    if (pick < 28) len = $urandom_range(0, 8);
    else if (pick < 36) len = $urandom_range(9, 40);
    else if (pick == 36) len = $urandom_range(200, LEN_MAX);
    else if (pick == 37) len = LEN_MAX;
    else len = $urandom_range(LEN_MAX + 1, 16'hFFFF);
    tx_frame.push_back(8'(len >> 8));
    tx_frame.push_back(8'(len));
    if (len > LEN_MAX) return;
    sum = SUM_SEED;
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom);
      // drop a framing byte into the data now and then
      if ($urandom_range(0, 63) == 0)
        b = $urandom_range(0, 1) ? live_regs[REG_START_BYTE] : live_regs[REG_END_BYTE];
      tx_frame.push_back(b);
      sum = sum + b;
    end
    tx_frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : sum);
    tx_frame.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom) : live_regs[REG_END_BYTE]);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side; every task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic pinned, input err_t err,
                           input logic fv);
    parse_result_t r;
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    r = parse_byte(b);
    if (pinned) begin
      r.error_code  = err;
      r.frame_valid = fv;
    end
    expected_results.push_back(r);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send in bursts with random gaps between them
  task automatic pace_sender();
    int unsigned gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = (tx_free_run || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, TX_MAX_GAP);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    tx_burst_left--;
  endtask

  // Hold the sender until every expected beat is in, then settle
  task automatic drain_results(input int unsigned settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Write reg_plan to all registers, one beat each
  task automatic apply_settings();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= reg_plan[i];
      do @(posedge clk); while (!cfg_ready);
      live_regs[i] = reg_plan[i];
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_traffic(input int unsigned quota);
    int unsigned sent;
    sent = 0;
    while (sent < quota) begin
      build_frame();
      // now and then let the parser run dry before the next frame
      if ($urandom_range(0, 14) == 0) drain_results(1);
      foreach (tx_frame[k]) begin
        pace_sender();
        push_byte(tx_frame[k], 1'b0, ERR_NONE, 1'b0);
      end
      sent += tx_frame.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, receiver stalls, result checking and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver pattern: steady, alternating ready and stall, then random stall bursts
  always @(negedge clk) begin
    rx_tick++;
    if (rx_stall != 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_tick / 96) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= (rx_tick % 2 == 0);
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            rx_stall = $urandom_range(1, RX_MAX_STALL - 1);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_data_valid, out_data_byte, out_data_index, out_source_id,
             out_message_count, out_error_code, out_frame_valid};
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected result beat: dv=%0b byte=%02h idx=%0d err=%0d fv=%0b",
                   got.data_valid, got.data_byte, got.data_index, got.error_code,
                   got.frame_valid);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("mismatch: exp dv=%0b byte=%02h idx=%0d src=%02h cnt=%02h err=%0d fv=%0b",
                     want.data_valid, want.data_byte, want.data_index, want.source_id,
                     want.message_count, want.error_code, want.frame_valid);
            $display("          got dv=%0b byte=%02h idx=%0d src=%02h cnt=%02h err=%0d fv=%0b",
                     got.data_valid, got.data_byte, got.data_index, got.source_id,
                     got.message_count, got.error_code, got.frame_valid);
          end
        end
        if (want.frame_valid) frames_good++;
        err_seen[want.error_code]++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d beats outstanding", cycle_count,
               expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_START_BYTE;
    cfg_data  = 8'h00;
    reset_parser_state();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table under reset settings
    foreach (directed_rows[n]) begin
      pace_sender();
      push_byte(directed_rows[n].value, directed_rows[n].pinned, directed_rows[n].err,
                directed_rows[n].fv);
    end
    run_random_traffic(RANDOM_BYTES);

    // register order: start, end, own, peer a, peer b, peer c, peer d
    for (int s = 1; s <= 4; s++) begin
      drain_results(3);
      case (s)
        1: foreach (reg_plan[i]) reg_plan[i] = 8'($urandom);
        2: reg_plan = '{8'h00, 8'hFF, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'hFE};
        3: reg_plan = '{8'h7E, 8'h7E, 8'h00, 8'h00, 8'h10, 8'h20, 8'h30};
        default: reg_plan = '{8'hFF, 8'h00, 8'h80, 8'h55, 8'h55, 8'h55, 8'h55};
      endcase
      // one setting runs with no sender gaps at all
      tx_free_run = (s == 2);
      apply_settings();
      run_random_traffic(RANDOM_BYTES);
    end

    drain_results(4);
    $display("Sent %0d bytes under %0d register settings; %0d frames completed cleanly",
             bytes_sent, settings_used + 1, frames_good);
    $display("Error beats by code 1-7: %0d %0d %0d %0d %0d %0d %0d; mismatches %0d",
             err_seen[1], err_seen[2], err_seen[3], err_seen[4], err_seen[5],
             err_seen[6], err_seen[7], failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[framed_message_byte_parser.f]
rtl/core/fmbp_pkg.sv
rtl/core/framed_message_byte_parser.sv
rtl/core/fmbp_checker.sv
tb/sv/framed_message_byte_parser_tb.sv
